// ----- rtl/core/rvm_pkg.sv -----
// Package for the radial vignette model evaluator.
// Holds field widths, opcode and register codes, fixed-point constants and the pixel clamp.
// Used by radial_vignette_model_eval_core; depends on nothing.
`default_nettype none

package rvm_pkg;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_COEFF = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_R2_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_DEG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_MODEL = 3'd4;

  localparam int CFG_DATA_W = 32;
  localparam int CENTER_W   = 18;
  localparam int INV_W      = 32;
  localparam int DEG_W      = 3;
  localparam int MEAN_W     = 25;
  localparam int SAMPLE_W   = 24;
  localparam int CIDX_W     = 3;
  localparam int COEF_W     = 32;
  localparam int MODEL_W    = 32;
  localparam int PIX_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int POW_W      = 20;
  localparam int RES_W      = 35;

  localparam logic [DEG_W-1:0] DEG_RESET = 3'd3;
  localparam logic [POW_W-1:0] U_MAX     = 20'hFFFFF;
  localparam logic [POW_W-1:0] ONE_Q16   = 20'h10000;

  localparam logic signed [MODEL_W-1:0] MODEL_MAX = 32'sh7FFFFFFF;
  localparam logic signed [MODEL_W-1:0] MODEL_MIN = 32'sh80000000;

  // Q.8 value to integer pixel, clamped to 0..65535
  function automatic logic [PIX_W-1:0] clamp_pixel(input logic signed [RES_W-1:0] q8);
    logic [PIX_W-1:0] r;
    if (q8[RES_W-1]) begin
      r = '0;
    end else if (|q8[RES_W-2:PIX_W+8]) begin
      r = '1;
    end else begin
      r = q8[PIX_W+7:8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/radial_vignette_model_eval_core.sv -----
// Radial vignette model evaluator, top level: pipeline, coefficient table, config registers.
// Depends on rvm_pkg.
//
// Takes one word per clock and, with the output taken every clock, delivers one result per
// clock. A pixel's result passes MAX_DEGREE + 7 registers: five stages for distance,
// squares, sum, reciprocal multiply and u, one stage per power u^2..u^MAX_DEGREE, then term,
// sum and output stages. Coefficient writes travel the same pipeline, update the table when
// they reach the term stage and give no result. Backpressure stalls only the stages that are
// full, so the input keeps taking words into empty stages.
`default_nettype none

module radial_vignette_model_eval_core
  import rvm_pkg::*;
#(
  parameter int MAX_DEGREE = 6,
  parameter int COORD_BITS = 10,
  localparam int IN_FIELDS_W = 2 * COORD_BITS + SAMPLE_W + CIDX_W + COEF_W,
  localparam int IN_TDATA_W  = (IN_FIELDS_W + 7) / 8 * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // config write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input word
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // tdata: pixel_x, pixel_y, sample_value, coeff_index, coeff_value, zero pad
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  // tuser: opcode
  input  wire logic                  in_tuser,
  // result word
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // tdata: model_value, model_pixel, residual_pixel
  output logic [MODEL_W+2*PIX_W-1:0] out_tdata
);

  localparam int PY_LSB   = COORD_BITS;
  localparam int SMP_LSB  = 2 * COORD_BITS;
  localparam int CIX_LSB  = SMP_LSB + SAMPLE_W;
  localparam int CVAL_LSB = CIX_LSB + CIDX_W;

  localparam int XW     = (COORD_BITS + 8 > CENTER_W) ? COORD_BITS + 8 : CENTER_W;
  localparam int D2W    = 2 * XW + 1;
  localparam int MW     = D2W + FRAC_W;
  localparam int TERM_W = COEF_W + POW_W - FRAC_W;
  localparam int SUM_W  = TERM_W + $clog2(MAX_DEGREE + 1) + 1;
  localparam int PROD_W = COEF_W + POW_W + 1;
  localparam int TS     = 4 + MAX_DEGREE;
  localparam int NST    = TS + 2;

  typedef logic [XW:0] ext_t;

  typedef struct packed {
    logic                              op;
    logic [SAMPLE_W-1:0]               sample;
    logic [CIDX_W-1:0]                 cidx;
    logic [COEF_W-1:0]                 cval;
    logic [XW-1:0]                     adx;
    logic [XW-1:0]                     ady;
    logic [2*XW-1:0]                   sqx;
    logic [2*XW-1:0]                   sqy;
    logic [D2W-1:0]                    d2;
    logic [MW-1:0]                     mhi;
    logic [MW-1:0]                     mlo;
    logic [MAX_DEGREE:0][POW_W-1:0]    pw;
    logic [MAX_DEGREE:0][TERM_W-1:0]   term;
    logic signed [MODEL_W-1:0]         model;
  } stage_t;

  logic [CENTER_W-1:0]             center_x_r;
  logic [CENTER_W-1:0]             center_y_r;
  logic [INV_W-1:0]                inv_r2_max_r;
  logic [DEG_W-1:0]                poly_degree_r;
  logic signed [MEAN_W-1:0]        mean_model_r;
  logic [MAX_DEGREE:0][COEF_W-1:0] coef_r;

  stage_t [NST-1:0]                pipe_r;
  logic   [NST-1:0]                pipe_v_r;
  stage_t [NST-1:0]                pipe_nxt;
  logic   [NST:0]                  rdy;
  logic   [DEG_W-1:0]              deg_eff;

  logic                            out_valid_r;
  logic [MODEL_W+2*PIX_W-1:0]      out_tdata_r;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      inv_r2_max_r  <= '0;
      poly_degree_r <= DEG_RESET;
      mean_model_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X:   center_x_r    <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:   center_y_r    <= cfg_data[CENTER_W-1:0];
        REG_INV_R2_MAX: inv_r2_max_r  <= cfg_data[INV_W-1:0];
        REG_POLY_DEG:   poly_degree_r <= cfg_data[DEG_W-1:0];
        REG_MEAN_MODEL: mean_model_r  <= cfg_data[MEAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (poly_degree_r == '0) begin
      deg_eff = DEG_W'(1);
    end else if (poly_degree_r > DEG_W'(MAX_DEGREE)) begin
      deg_eff = DEG_W'(MAX_DEGREE);
    end else begin
      deg_eff = poly_degree_r;
    end
  end

  // stage handshake
  assign rdy[NST]  = !out_valid_r || out_tready;
  assign in_tready = rdy[0];

  for (genvar s = 0; s < NST; s++) begin : g_st
    assign rdy[s] = !pipe_v_r[s] || rdy[s+1];

    if (s == 0) begin : g_dist
      always_comb begin
        ext_t px, py, cx, cy, ddx, ddy;
        px  = ext_t'({in_tdata[PY_LSB-1:0], 8'h00});
        py  = ext_t'({in_tdata[SMP_LSB-1:PY_LSB], 8'h00});
        cx  = ext_t'(center_x_r);
        cy  = ext_t'(center_y_r);
        ddx = px - cx;
        ddy = py - cy;
        pipe_nxt[s]        = pipe_r[s];
        pipe_nxt[s].op     = in_tuser;
        pipe_nxt[s].sample = in_tdata[CIX_LSB-1:SMP_LSB];
        pipe_nxt[s].cidx   = in_tdata[CVAL_LSB-1:CIX_LSB];
        pipe_nxt[s].cval   = in_tdata[CVAL_LSB+COEF_W-1:CVAL_LSB];
        pipe_nxt[s].adx    = ddx[XW] ? XW'(cx - px) : ddx[XW-1:0];
        pipe_nxt[s].ady    = ddy[XW] ? XW'(cy - py) : ddy[XW-1:0];
      end
    end else if (s == 1) begin : g_sq
      always_comb begin
        pipe_nxt[s]     = pipe_r[s-1];
        pipe_nxt[s].sqx = (2*XW)'(pipe_r[s-1].adx) * (2*XW)'(pipe_r[s-1].adx);
        pipe_nxt[s].sqy = (2*XW)'(pipe_r[s-1].ady) * (2*XW)'(pipe_r[s-1].ady);
      end
    end else if (s == 2) begin : g_d2
      always_comb begin
        pipe_nxt[s]    = pipe_r[s-1];
        pipe_nxt[s].d2 = D2W'(pipe_r[s-1].sqx) + D2W'(pipe_r[s-1].sqy);
      end
    end else if (s == 3) begin : g_mul
      always_comb begin
        pipe_nxt[s]     = pipe_r[s-1];
        pipe_nxt[s].mhi = MW'(pipe_r[s-1].d2) * MW'(inv_r2_max_r[INV_W-1:FRAC_W]);
        pipe_nxt[s].mlo = MW'(pipe_r[s-1].d2) * MW'(inv_r2_max_r[FRAC_W-1:0]);
      end
    end else if (s == 4) begin : g_u
      always_comb begin
        logic [MW:0] ssum;
        ssum = (MW+1)'(pipe_r[s-1].mhi) + (MW+1)'(pipe_r[s-1].mlo[MW-1:FRAC_W]);
        pipe_nxt[s]       = pipe_r[s-1];
        pipe_nxt[s].pw[0] = ONE_Q16;
        pipe_nxt[s].pw[1] = (|ssum[MW:FRAC_W+POW_W]) ? U_MAX : ssum[FRAC_W+POW_W-1:FRAC_W];
      end
    end else if (s < TS) begin : g_pow
      localparam int J = s - 3;
      always_comb begin
        logic [2*POW_W-1:0] pp;
        pp = (2*POW_W)'(pipe_r[s-1].pw[J-1]) * (2*POW_W)'(pipe_r[s-1].pw[1]);
        pipe_nxt[s]       = pipe_r[s-1];
        pipe_nxt[s].pw[J] = (|pp[2*POW_W-1:FRAC_W+POW_W]) ? U_MAX :
                            pp[FRAC_W+POW_W-1:FRAC_W];
      end
    end else if (s == TS) begin : g_term
      always_comb begin
        logic signed [PROD_W-1:0] prod;
        pipe_nxt[s] = pipe_r[s-1];
        for (int k = 0; k <= MAX_DEGREE; k++) begin
          prod = PROD_W'($signed(coef_r[k])) * PROD_W'($signed({1'b0, pipe_r[s-1].pw[k]}));
          pipe_nxt[s].term[k] = (DEG_W'(k) <= deg_eff) ?
                                prod[FRAC_W+TERM_W-1:FRAC_W] : '0;
        end
      end
    end else begin : g_sum
      always_comb begin
        logic signed [SUM_W-1:0] acc;
        acc = '0;
        for (int k = 0; k <= MAX_DEGREE; k++) begin
          acc = acc + SUM_W'($signed(pipe_r[s-1].term[k]));
        end
        pipe_nxt[s] = pipe_r[s-1];
        if (acc[SUM_W-1:MODEL_W-1] == '0 || acc[SUM_W-1:MODEL_W-1] == '1) begin
          pipe_nxt[s].model = acc[MODEL_W-1:0];
        end else begin
          pipe_nxt[s].model = acc[SUM_W-1] ? MODEL_MIN : MODEL_MAX;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        pipe_v_r[s] <= (s == 0) ? in_tvalid : pipe_v_r[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        pipe_r[s] <= pipe_nxt[s];
      end
    end
  end

  // coefficient table, written as the write word enters the term stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (rdy[TS] && pipe_v_r[TS-1] && pipe_r[TS-1].op == OP_COEFF) begin
      for (int k = 0; k <= MAX_DEGREE; k++) begin
        if (pipe_r[TS-1].cidx == CIDX_W'(k)) begin
          coef_r[k] <= pipe_r[TS-1].cval;
        end
      end
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[NST]) begin
      out_valid_r <= pipe_v_r[NST-1] && pipe_r[NST-1].op == OP_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [RES_W-1:0] mdl, resid;
    mdl   = RES_W'(pipe_r[NST-1].model);
    resid = $signed({{(RES_W-SAMPLE_W){1'b0}}, pipe_r[NST-1].sample}) - mdl +
            RES_W'(mean_model_r);
    if (rdy[NST]) begin
      out_tdata_r <= {clamp_pixel(resid), clamp_pixel(mdl), pipe_r[NST-1].model};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire
